// ===== design/srtf_scheduler_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef SRTF_SCHEDULER_ASSERT_SVH
`define SRTF_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRTF_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("srtf_scheduler: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRTF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("srtf_scheduler: assertion failed");

`endif

// ===== design/srtf_pkg.sv =====
package srtf_pkg;

  localparam int unsigned SLOT_W         = 4;
  localparam int unsigned FIELD_W        = 16;
  localparam int unsigned DEF_TASK_SLOTS = 16;
  localparam int unsigned DEF_TIME_BITS  = 16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic               action;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
  } in_item_t;

  typedef struct packed {
    logic               idle;
    logic [SLOT_W-1:0]  running_slot;
    logic               finished;
    logic [FIELD_W-1:0] turnaround;
    logic [FIELD_W-1:0] waiting;
    logic [FIELD_W-1:0] time_now;
    logic               all_clear;
    logic               block_closed;
    logic [SLOT_W-1:0]  closed_slot;
    logic [FIELD_W-1:0] closed_len;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_rd;
    logic scan_cmp;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage

// ===== design/srtf_chan_if.sv =====
interface srtf_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/srtf_ctrl.sv =====
module srtf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  input  logic              out_ready,
  input  srtf_pkg::dp_stat_t stat,
  output logic              in_ready,
  output logic              out_valid,
  output srtf_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   cmp_r;
  logic   accept;
  logic   out_free;

  always_comb begin
    in_ready       = (state_r == S_IDLE);
    accept         = in_valid && in_ready;
    out_free       = !out_valid_r || out_ready;
    cmd.capture    = accept;
    cmd.scan_start = accept && (in_action == srtf_pkg::ACT_TICK);
    cmd.scan_rd    = (state_r == S_SCAN);
    cmd.scan_cmp   = cmp_r;
    cmd.commit     = (state_r == S_COMMIT) && out_free;
    out_valid_nxt  = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    state_nxt      = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_action == srtf_pkg::ACT_TICK) ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_r       <= cmd.scan_rd;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/srtf_dp.sv =====
module srtf_dp #(
  parameter int unsigned TASK_SLOTS = srtf_pkg::DEF_TASK_SLOTS,
  parameter int unsigned TIME_BITS  = srtf_pkg::DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  srtf_pkg::ctl_cmd_t  cmd,
  input  srtf_pkg::in_item_t  in_data,
  output srtf_pkg::dp_stat_t  stat,
  output srtf_pkg::out_item_t out_data
);

  localparam int unsigned SLOT_BITS = $clog2(TASK_SLOTS);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  logic [TIME_BITS-1:0] rem_mem [TASK_SLOTS];
  logic [TIME_BITS-1:0] arr_mem [TASK_SLOTS];
  logic [TIME_BITS-1:0] bur_mem [TASK_SLOTS];

  srtf_pkg::in_item_t  item_r;
  srtf_pkg::out_item_t out_r, out_nxt;

  logic [TASK_SLOTS-1:0] nz_r, nz_nxt;
  logic [TIME_BITS-1:0]  clock_r, clock_nxt;
  logic [SLOT_BITS-1:0]  last_r, last_nxt;
  logic                  open_r, open_nxt;
  logic [TIME_BITS-1:0]  blen_r, blen_nxt;

  logic [SLOT_BITS-1:0]  idx_r;
  logic [SLOT_BITS-1:0]  cmp_idx_r;
  logic [TIME_BITS-1:0]  rd_rem_r, rd_arr_r, rd_bur_r;

  logic                  best_found_r;
  logic [SLOT_BITS-1:0]  best_idx_r;
  logic [TIME_BITS-1:0]  best_rem_r, best_arr_r, best_bur_r;

  logic                  is_load;
  logic                  ld_ok;
  logic [SLOT_BITS-1:0]  ld_idx;
  logic [TIME_BITS-1:0]  ld_arr, ld_bur;
  logic                  cand, take;
  logic [TIME_BITS-1:0]  rem_dec, clk_inc, blen_inc, ta;
  logic [TIME_BITS:0]    wdiff;
  logic [TIME_BITS-1:0]  wt;
  logic                  close;
  logic                  done_now;

  always_comb begin
    is_load = (item_r.action == srtf_pkg::ACT_LOAD);
    ld_ok   = (int'(item_r.slot) < TASK_SLOTS);
    ld_idx  = SLOT_BITS'(item_r.slot);
    ld_arr  = TIME_BITS'(item_r.arrival);
    ld_bur  = TIME_BITS'(item_r.burst);

    stat.scan_last = (idx_r == SLOT_BITS'(TASK_SLOTS - 1));

    cand = nz_r[cmp_idx_r] && (rd_arr_r <= clock_r);
    take = cand && (!best_found_r || (rd_rem_r < best_rem_r) ||
                    ((rd_rem_r == best_rem_r) && (rd_arr_r < best_arr_r)));

    rem_dec  = best_rem_r - TIME_BITS'(1);
    clk_inc  = (clock_r == TIME_MAX) ? clock_r : clock_r + TIME_BITS'(1);
    blen_inc = (blen_r == TIME_MAX) ? blen_r : blen_r + TIME_BITS'(1);
    ta       = clk_inc - best_arr_r;
    wdiff    = {1'b0, ta} - {1'b0, best_bur_r};
    wt       = wdiff[TIME_BITS] ? '0 : wdiff[TIME_BITS-1:0];
    close    = open_r && (!best_found_r || (last_r != best_idx_r));
    done_now = best_found_r && (rem_dec == '0);

    nz_nxt    = nz_r;
    clock_nxt = clock_r;
    last_nxt  = last_r;
    open_nxt  = open_r;
    blen_nxt  = blen_r;
    out_nxt   = '0;

    if (is_load) begin
      if (ld_ok) begin
        nz_nxt[ld_idx] = (ld_bur != '0);
      end
    end else begin
      clock_nxt = clk_inc;
      open_nxt  = best_found_r;
      if (best_found_r) begin
        nz_nxt[best_idx_r] = (rem_dec != '0);
        last_nxt = best_idx_r;
        blen_nxt = (open_r && (last_r == best_idx_r)) ? blen_inc : TIME_BITS'(1);
      end else begin
        blen_nxt = '0;
      end
      out_nxt.idle         = !best_found_r;
      out_nxt.running_slot = best_found_r ? srtf_pkg::SLOT_W'(best_idx_r) : '0;
      out_nxt.finished     = done_now;
      out_nxt.turnaround   = done_now ? srtf_pkg::FIELD_W'(ta) : '0;
      out_nxt.waiting      = done_now ? srtf_pkg::FIELD_W'(wt) : '0;
      out_nxt.block_closed = close;
      out_nxt.closed_slot  = close ? srtf_pkg::SLOT_W'(last_r) : '0;
      out_nxt.closed_len   = close ? srtf_pkg::FIELD_W'(blen_r) : '0;
    end
    out_nxt.time_now  = srtf_pkg::FIELD_W'(clock_nxt);
    out_nxt.all_clear = ~|nz_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (is_load) begin
        if (ld_ok) begin
          rem_mem[ld_idx] <= ld_bur;
          arr_mem[ld_idx] <= ld_arr;
          bur_mem[ld_idx] <= ld_bur;
        end
      end else if (best_found_r) begin
        rem_mem[best_idx_r] <= rem_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_rem_r  <= rem_mem[idx_r];
      rd_arr_r  <= arr_mem[idx_r];
      rd_bur_r  <= bur_mem[idx_r];
      cmp_idx_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_rd) begin
      idx_r <= idx_r + SLOT_BITS'(1);
    end
    if (cmd.scan_cmp && take) begin
      best_idx_r <= cmp_idx_r;
      best_rem_r <= rd_rem_r;
      best_arr_r <= rd_arr_r;
      best_bur_r <= rd_bur_r;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r         <= '0;
      clock_r      <= '0;
      last_r       <= '0;
      open_r       <= 1'b0;
      blen_r       <= '0;
      best_found_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        nz_r    <= nz_nxt;
        clock_r <= clock_nxt;
        last_r  <= last_nxt;
        open_r  <= open_nxt;
        blen_r  <= blen_nxt;
      end
      if (cmd.scan_start) begin
        best_found_r <= 1'b0;
      end else if (cmd.scan_cmp && take) begin
        best_found_r <= 1'b1;
      end
    end
  end

  assign out_data = out_r;

endmodule

// ===== design/srtf_scheduler.sv =====
// Shortest-remaining-time-first scheduler over TASK_SLOTS task slots. A load
// request writes one slot's arrival time and burst; a tick request picks the
// arrived slot with the least remaining work (ties to the earlier arrival, then
// the lower slot), charges it one unit, advances the saturating clock and
// reports completions and closed run blocks. Every request returns exactly one
// result. A load goes straight to the update; a tick reads the slot tables
// through their single read port, one slot per cycle, makes the last compare in
// a drain state and then the update, which waits for a free output register. A
// finished result may wait in the output register while the next request is
// accepted; it is written there only once the previous one is taken.
module srtf_scheduler #(
  parameter int unsigned TASK_SLOTS = srtf_pkg::DEF_TASK_SLOTS,
  parameter int unsigned TIME_BITS  = srtf_pkg::DEF_TIME_BITS
) (
  input logic        clk,
  input logic        rst_n,
  srtf_chan_if.sink   in_req,
  srtf_chan_if.source out_rsp
);

  srtf_pkg::ctl_cmd_t  cmd;
  srtf_pkg::dp_stat_t  stat;
  srtf_pkg::in_item_t  in_data;
  srtf_pkg::out_item_t out_data;
  logic                in_ready;
  logic                out_valid;

  assign in_data = in_req.data;

  srtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_action (in_data.action),
    .out_ready (out_rsp.ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  srtf_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

  assign in_req.ready  = in_ready;
  assign out_rsp.valid = out_valid;
  assign out_rsp.data  = out_data;

endmodule

// ===== design/srtf_chk.sv =====
`include "srtf_scheduler_assert.svh"

module srtf_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input srtf_pkg::out_item_t out_data
);

  `SRTF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `SRTF_ASSERT_NEXT(a_one_request, clk, rst_n, in_valid && in_ready, !in_ready)
  `SRTF_ASSERT_IMPL(a_idle_quiet, clk, rst_n, out_valid && out_data.idle, !out_data.finished && (out_data.running_slot == '0))

endmodule

bind srtf_scheduler srtf_chk u_srtf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_data  (out_rsp.data)
);
